// ===== src/kcl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and codes for the keypad code lock with history.
// ----------------------------------------------------------------------------
package kcl_pkg;

  typedef enum logic [1:0] {
    MODE_SETUP   = 2'd0,
    MODE_LOCKED  = 2'd1,
    MODE_OPEN    = 2'd2,
    MODE_NEWCODE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_DIGIT   = 3'd0,
    EV_SET     = 3'd1,
    EV_WRONG   = 3'd2,
    EV_UNLOCK  = 3'd3,
    EV_OLD     = 3'd4,
    EV_UPDATED = 3'd5,
    EV_RELOCK  = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  localparam int unsigned KEY_W = 4;

endpackage
`default_nettype wire

// ===== src/kcl_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kcl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/keypad_code_lock_with_history_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_code_lock_with_history_top
// Keypad code lock with a ring of previously used codes.
// ----------------------------------------------------------------------------
// Each accepted key item gives one result item. The key that completes a
// new code walks the filled part of the history RAM through its single
// read port, one entry per cycle; no new key is taken during the walk.
// A key is taken once the previous result has left the output register.
// History entries count as valid below a fill count, so no clearing pass
// is needed after reset.
module keypad_code_lock_with_history_top
  import kcl_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 16,
  parameter int unsigned CODE_DIGITS   = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             change_key_we,
  input  wire logic [KEY_W-1:0] change_key_index,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [KEY_W-1:0] key_index,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [2:0]            event_code,
  output logic [2:0]            digits_entered,
  output logic [1:0]            lock_mode
);

  localparam int unsigned CODE_W = KEY_W * CODE_DIGITS;
  localparam int unsigned CNT_W  = $clog2(CODE_DIGITS + 1);
  localparam int unsigned HIDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);

  state_t             state;
  mode_t              mode;
  logic [KEY_W-1:0]   change_key;
  logic [CODE_W-1:0]  entry_digits;
  logic [CNT_W-1:0]   digit_count;
  logic [CODE_W-1:0]  current_code;
  logic [CODE_W-1:0]  pend_code;
  logic [HIDX_W-1:0]  history_next;
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  issue_idx;
  logic               pend;
  logic               hit;

  logic               accept;
  logic [CODE_W-1:0]  entry_shift;
  logic [CNT_W-1:0]   count_inc;
  logic               done;
  logic               scan_start;
  logic               scan_finish;
  logic               out_load;
  logic               issue;
  logic               ram_we;
  logic [CODE_W-1:0]  ram_wdata;
  logic [CODE_W-1:0]  ram_rdata;
  logic [HIDX_W-1:0]  history_next_next;
  logic [FILL_W-1:0]  fill_next;

  assign in_stall    = (state != S_IDLE) || (out_valid && out_stall);
  assign accept      = in_valid && !in_stall;
  assign entry_shift = (entry_digits << KEY_W) | CODE_W'(key_index);
  assign count_inc   = digit_count + CNT_W'(1);
  assign done        = count_inc >= CNT_W'(CODE_DIGITS);
  assign scan_start  = accept && (mode == MODE_NEWCODE) && done;
  assign scan_finish = (state == S_SCAN) && !pend && (issue_idx == fill);
  assign out_load    = (accept && !scan_start) || scan_finish;
  assign issue       = (state == S_SCAN) && (issue_idx < fill);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = pend_code;
    if (accept && (mode == MODE_SETUP) && done) begin
      ram_we    = 1'b1;
      ram_wdata = entry_shift;
    end else if (scan_finish && !hit) begin
      ram_we = 1'b1;
    end
    history_next_next = (history_next == HIDX_W'(HISTORY_DEPTH - 1)) ? '0
                        : history_next + HIDX_W'(1);
    fill_next = (fill == FILL_W'(HISTORY_DEPTH)) ? fill : fill + FILL_W'(1);
  end

  kcl_ram #(
    .WIDTH (CODE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (history_next),
    .wdata (ram_wdata),
    .raddr (issue_idx[HIDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mode         <= MODE_SETUP;
      change_key   <= KEY_W'(12);
      entry_digits <= '0;
      digit_count  <= '0;
      current_code <= '0;
      history_next <= '0;
      fill         <= '0;
      issue_idx    <= '0;
      pend         <= 1'b0;
      hit          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (change_key_we) begin
        change_key <= change_key_index;
      end
      out_valid <= out_load || (out_valid && out_stall);
      if (ram_we) begin
        history_next <= history_next_next;
        fill         <= fill_next;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (mode == MODE_OPEN) begin
              entry_digits   <= '0;
              digit_count    <= '0;
              digits_entered <= 3'd0;
              if (key_index == change_key) begin
                mode       <= MODE_NEWCODE;
                event_code <= EV_DIGIT;
                lock_mode  <= MODE_NEWCODE;
              end else begin
                mode       <= MODE_LOCKED;
                event_code <= EV_RELOCK;
                lock_mode  <= MODE_LOCKED;
              end
            end else if (!done) begin
              entry_digits   <= entry_shift;
              digit_count    <= count_inc;
              event_code     <= EV_DIGIT;
              digits_entered <= 3'(count_inc);
              lock_mode      <= mode;
            end else begin
              entry_digits   <= '0;
              digit_count    <= '0;
              digits_entered <= 3'(count_inc);
              unique case (mode)
                MODE_SETUP: begin
                  current_code <= entry_shift;
                  mode         <= MODE_LOCKED;
                  event_code   <= EV_SET;
                  lock_mode    <= MODE_LOCKED;
                end
                MODE_LOCKED: begin
                  if (entry_shift == current_code) begin
                    mode       <= MODE_OPEN;
                    event_code <= EV_UNLOCK;
                    lock_mode  <= MODE_OPEN;
                  end else begin
                    event_code <= EV_WRONG;
                    lock_mode  <= MODE_LOCKED;
                  end
                end
                default: begin
                  // new code: check it against the history ring
                  pend_code <= entry_shift;
                  issue_idx <= '0;
                  pend      <= 1'b0;
                  hit       <= 1'b0;
                  state     <= S_SCAN;
                end
              endcase
            end
          end
        end
        S_SCAN: begin
          pend <= issue;
          if (issue) begin
            issue_idx <= issue_idx + FILL_W'(1);
          end
          if (pend && (ram_rdata == pend_code)) begin
            hit <= 1'b1;
          end
          if (scan_finish) begin
            state <= S_IDLE;
            if (hit) begin
              event_code <= EV_OLD;
              lock_mode  <= MODE_NEWCODE;
            end else begin
              current_code <= pend_code;
              mode         <= MODE_LOCKED;
              event_code   <= EV_UPDATED;
              lock_mode    <= MODE_LOCKED;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
